/* design/dqc_pkg.sv */
// Shared types and constants for the int8 dequantizer with corrections.
`timescale 1ns / 1ps

package dqc_pkg;

	localparam int MAX_CHANNELS_DEF = 256;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_DEQUANT = 1'b1;

	typedef enum logic [1:0] {
		REG_PER_CHANNEL   = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_INNER_STRIDE  = 2'd2,
		REG_HALF_OUTPUT   = 2'd3
	} dqc_reg_t;

	typedef enum logic [1:0] {
		OP_CVT = 2'd0,
		OP_MUL = 2'd1,
		OP_ADD = 2'd2
	} dqc_op_t;

	typedef struct packed {
		logic              cmd;
		logic signed [7:0] sample;
		logic              first;
		logic [7:0]        entry;
		logic [31:0]       scale_bits;
		logic signed [7:0] zero_point;
		logic [31:0]       mean_bits;
		logic [31:0]       var_bits;
	} dqc_in_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic [7:0]  channel_used;
	} dqc_out_t;

	typedef struct packed {
		logic [31:0] scale_bits;
		logic [7:0]  zero_point;
		logic [31:0] mean_bits;
		logic [31:0] var_bits;
	} dqc_entry_t;

	typedef struct packed {
		logic pre;
		logic norm;
		logic rnd;
	} dqc_fpu_ctl_t;

endpackage

/* design/dqc_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module dqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/dqc_fpu.sv */
// Shared float32 unit: int-to-float, multiply and add in three registered steps.
`timescale 1ns / 1ps

module dqc_fpu (
	input  logic                 clk,
	input  dqc_pkg::dqc_fpu_ctl_t ctl,
	input  dqc_pkg::dqc_op_t     op,
	input  logic [31:0]          b_bits,
	input  logic signed [8:0]    diff,
	output logic [31:0]          res
);

	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

	logic [31:0] a_bits;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0] ea, eb;

	logic pre_spec, pre_sign, pre_zsign;
	logic [31:0] pre_bits;
	logic [47:0] pre_v;
	logic signed [10:0] pre_x;

	logic swap;
	logic [31:0] big, sml;
	logic [7:0] eg, es, d;
	logic [23:0] mg, ms;
	logic [26:0] sm_ext, sm, lost;
	logic [27:0] sum;
	logic [8:0] mag;

	logic spec_s1, sign_s1, zsign_s1;
	logic [31:0] bits_s1;
	logic [47:0] v_s1;
	logic signed [10:0] x_s1;

	logic [5:0] lz;

	logic spec_s2, sign_s2, zsign_s2, vzero_s2;
	logic [31:0] bits_s2;
	logic [47:0] n_s2;
	logic signed [10:0] e_s2;

	logic [7:0] sh, e_eff;
	logic [47:0] shifted, lost_n;
	logic sticky, g, r;
	logic [22:0] frac;
	logic [30:0] packed_v;
	logic [31:0] rnd_res;
	logic [31:0] res_q;

	assign a_bits = res_q;
	assign res = res_q;

	always_comb begin
		a_nan  = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] != 23'd0);
		b_nan  = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] != 23'd0);
		a_inf  = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] == 23'd0);
		b_inf  = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] == 23'd0);
		a_zero = (a_bits[30:0] == 31'd0);
		b_zero = (b_bits[30:0] == 31'd0);
		ma = {a_bits[30:23] != 8'd0, a_bits[22:0]};
		mb = {b_bits[30:23] != 8'd0, b_bits[22:0]};
		ea = (a_bits[30:23] == 8'd0) ? 8'd1 : a_bits[30:23];
		eb = (b_bits[30:23] == 8'd0) ? 8'd1 : b_bits[30:23];

		swap = a_bits[30:0] < b_bits[30:0];
		big  = swap ? b_bits : a_bits;
		sml  = swap ? a_bits : b_bits;
		eg   = swap ? eb : ea;
		es   = swap ? ea : eb;
		mg   = swap ? mb : ma;
		ms   = swap ? ma : mb;
		d    = eg - es;
		sm_ext = {ms, 3'b000};
		if (d >= 8'd27) begin
			sm   = 27'd0;
			lost = sm_ext;
		end else begin
			sm   = sm_ext >> d;
			lost = sm_ext & ((27'd1 << d) - 27'd1);
		end
		sm = sm | {26'd0, |lost};
		if (big[31] == sml[31]) begin
			sum = {1'b0, mg, 3'b000} + {1'b0, sm};
		end else begin
			sum = {1'b0, mg, 3'b000} - {1'b0, sm};
		end
		mag = diff[8] ? 9'(-diff) : 9'(diff);

		pre_spec  = 1'b0;
		pre_bits  = 32'd0;
		pre_sign  = 1'b0;
		pre_zsign = 1'b0;
		pre_v     = 48'd0;
		pre_x     = 11'sd0;
		unique case (op)
			dqc_pkg::OP_CVT: begin
				pre_sign = diff[8];
				pre_v    = {mag, 39'd0};
				pre_x    = 11'sd135;
			end
			dqc_pkg::OP_MUL: begin
				pre_sign  = a_bits[31] ^ b_bits[31];
				pre_zsign = pre_sign;
				pre_v     = ma * mb;
				pre_x     = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
				if (a_nan) begin
					pre_spec = 1'b1;
					pre_bits = a_bits | QUIET_BIT;
				end else if (b_nan) begin
					pre_spec = 1'b1;
					pre_bits = b_bits | QUIET_BIT;
				end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
					pre_spec = 1'b1;
					pre_bits = DEFAULT_NAN;
				end else if (a_inf || b_inf) begin
					pre_spec = 1'b1;
					pre_bits = {pre_sign, 8'hFF, 23'd0};
				end
			end
			dqc_pkg::OP_ADD: begin
				pre_sign  = big[31];
				pre_zsign = a_bits[31] & b_bits[31];
				pre_v     = {sum, 20'd0};
				pre_x     = $signed({3'b000, eg}) + 11'sd1;
				if (a_nan) begin
					pre_spec = 1'b1;
					pre_bits = a_bits | QUIET_BIT;
				end else if (b_nan) begin
					pre_spec = 1'b1;
					pre_bits = b_bits | QUIET_BIT;
				end else if (a_inf && b_inf && (a_bits[31] != b_bits[31])) begin
					pre_spec = 1'b1;
					pre_bits = DEFAULT_NAN;
				end else if (a_inf) begin
					pre_spec = 1'b1;
					pre_bits = a_bits;
				end else if (b_inf) begin
					pre_spec = 1'b1;
					pre_bits = b_bits;
				end
			end
			default: begin
				pre_spec = 1'b1;
				pre_bits = DEFAULT_NAN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.pre) begin
			spec_s1  <= pre_spec;
			bits_s1  <= pre_bits;
			sign_s1  <= pre_sign;
			zsign_s1 <= pre_zsign;
			v_s1     <= pre_v;
			x_s1     <= pre_x;
		end
	end

	always_comb begin
		lz = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v_s1[i]) begin
				lz = 6'(47 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.norm) begin
			spec_s2  <= spec_s1;
			bits_s2  <= bits_s1;
			sign_s2  <= sign_s1;
			zsign_s2 <= zsign_s1;
			vzero_s2 <= (v_s1 == 48'd0);
			n_s2     <= v_s1 << lz;
			e_s2     <= x_s1 - $signed({5'd0, lz});
		end
	end

	always_comb begin
		if (e_s2 <= 11'sd0) begin
			sh    = 8'(11'sd1 - e_s2);
			e_eff = 8'd0;
		end else begin
			sh    = 8'd0;
			e_eff = e_s2[7:0];
		end
		if (sh >= 8'd48) begin
			shifted = 48'd0;
			lost_n  = n_s2;
		end else begin
			shifted = n_s2 >> sh;
			lost_n  = n_s2 & ((48'd1 << sh) - 48'd1);
		end
		sticky   = |lost_n;
		frac     = shifted[46:24];
		g        = shifted[23];
		r        = (|shifted[22:0]) | sticky;
		packed_v = {e_eff, frac} + {30'd0, g & (r | frac[0])};
		if (spec_s2) begin
			rnd_res = bits_s2;
		end else if (vzero_s2) begin
			rnd_res = {zsign_s2, 31'd0};
		end else if (e_s2 >= 11'sd255) begin
			rnd_res = {sign_s2, 8'hFF, 23'd0};
		end else begin
			rnd_res = {sign_s2, packed_v};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rnd) begin
			res_q <= rnd_res;
		end
	end

endmodule

/* design/int8_dequant_with_corrections.sv */
// Top level of the int8 dequantizer with scale, variance and mean corrections.
// A load item writes the parameter RAM at its transfer edge if its entry is in range.
// A dequantize item passes a RAM read, then the pre, norm and rnd registers of the
// shared float unit for each of four steps, then the output register, held on stall.
// A new item is taken only in the idle state, after the last dequantize item is out.
// Reset sets config defaults, clears state and counters; RAM is undefined until loaded.
`timescale 1ns / 1ps

module int8_dequant_with_corrections #(
	parameter int MAX_CHANNELS = dqc_pkg::MAX_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dqc_pkg::dqc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output dqc_pkg::dqc_out_t out_data,
	input  logic              cfg_we,
	input  dqc_pkg::dqc_reg_t cfg_index,
	input  logic [24:0]       cfg_data
);

	localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNTW = ($clog2(MAX_CHANNELS + 1) > 9) ? $clog2(MAX_CHANNELS + 1) : 9;
	localparam int EW   = $bits(dqc_pkg::dqc_entry_t);
	localparam logic [CNTW-1:0] MAX_C = CNTW'(MAX_CHANNELS);
	localparam logic [24:0] STRIDE_MAX = 25'h100_0000;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_PRE  = 6'b000100,
		ST_NORM = 6'b001000,
		ST_RND  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		STEP_CVT   = 2'd0,
		STEP_SCALE = 2'd1,
		STEP_VAR   = 2'd2,
		STEP_MEAN  = 2'd3
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic        per_channel_q, half_output_q;
	logic [8:0]  channel_count_q;
	logic [24:0] inner_stride_q;
	logic [24:0] ip_q;
	logic [AW-1:0] ch_q;

	logic signed [7:0] x_q;
	logic [CNTW-1:0]   idx_q;
	logic              out_valid_q;
	dqc_pkg::dqc_out_t out_q;

	logic accept, is_load, is_deq, load_ok, out_free;
	logic [CNTW-1:0] entry_ext, ch_cur_ext, ch_next, count_eff, idx;
	logic [24:0] ip_cur, ip_next, stride_eff;
	logic [AW-1:0] ch_cur;

	dqc_pkg::dqc_entry_t wentry, rentry;
	logic [EW-1:0]       rdata;
	dqc_pkg::dqc_fpu_ctl_t fctl;
	dqc_pkg::dqc_op_t    fop;
	logic [31:0]         fb, fres, result;
	logic signed [8:0]   diff;

	function automatic logic [15:0] round_shift(input logic [23:0] m, input logic [4:0] s);
		logic [24:0] q, rem, halfway;
		q       = {1'b0, m} >> s;
		rem     = {1'b0, m} & ((25'd1 << s) - 25'd1);
		halfway = 25'd1 << (s - 5'd1);
		if ((rem > halfway) || ((rem == halfway) && q[0])) begin
			q = q + 25'd1;
		end
		return q[15:0];
	endfunction

	function automatic logic [31:0] to_half(input logic [31:0] f);
		logic [15:0] sgn;
		logic [7:0]  ex;
		logic [22:0] mant, m;
		sgn  = {f[31], 15'd0};
		ex   = f[30:23];
		mant = f[22:0];
		m    = 23'({ex - 8'd112, 13'd0}) | mant;
		if (ex == 8'hFF) begin
			return {16'd0, sgn | ((mant != 23'd0) ? 16'h7E00 : 16'h7C00)};
		end else if (ex >= 8'd143) begin
			return {16'd0, sgn | 16'h7C00};
		end else if (ex >= 8'd113) begin
			return {16'd0, sgn | round_shift({1'b0, m}, 5'd13)};
		end else if (ex < 8'd102) begin
			return {16'd0, sgn};
		end else begin
			return {16'd0, sgn | round_shift({1'b1, mant}, 5'(8'd126 - ex))};
		end
	endfunction

	assign accept  = in_valid && !in_stall;
	assign is_load = accept && (in_data.cmd == dqc_pkg::CMD_LOAD);
	assign is_deq  = accept && (in_data.cmd == dqc_pkg::CMD_DEQUANT);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign entry_ext = CNTW'(in_data.entry);
	assign load_ok   = entry_ext < MAX_C;
	assign wentry    = '{scale_bits: in_data.scale_bits, zero_point: in_data.zero_point,
		mean_bits: in_data.mean_bits, var_bits: in_data.var_bits};

	always_comb begin
		ch_cur     = in_data.first ? '0 : ch_q;
		ip_cur     = in_data.first ? 25'd0 : ip_q;
		ch_cur_ext = CNTW'(ch_cur);
		idx        = per_channel_q ? ch_cur_ext : '0;
		stride_eff = (inner_stride_q == 25'd0) ? 25'd1 :
			((inner_stride_q > STRIDE_MAX) ? STRIDE_MAX : inner_stride_q);
		count_eff  = (channel_count_q == 9'd0) ? CNTW'(1) :
			((CNTW'(channel_count_q) > MAX_C) ? MAX_C : CNTW'(channel_count_q));
		ip_next    = ip_cur + 25'd1;
		ch_next    = ch_cur_ext + CNTW'(1);
		if (ch_next >= count_eff) begin
			ch_next = '0;
		end
	end

	dqc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (is_load && load_ok),
		.waddr(entry_ext[AW-1:0]),
		.wdata(wentry),
		.re   (is_deq),
		.raddr(idx[AW-1:0]),
		.rdata(rdata)
	);

	assign rentry = rdata;
	assign diff   = $signed({x_q[7], x_q}) - $signed({rentry.zero_point[7], rentry.zero_point});

	always_comb begin
		fctl.pre  = (state_q == ST_PRE);
		fctl.norm = (state_q == ST_NORM);
		fctl.rnd  = (state_q == ST_RND);
		unique case (step_q)
			STEP_CVT: begin
				fop = dqc_pkg::OP_CVT;
				fb  = rentry.scale_bits;
			end
			STEP_SCALE: begin
				fop = dqc_pkg::OP_MUL;
				fb  = rentry.scale_bits;
			end
			STEP_VAR: begin
				fop = dqc_pkg::OP_MUL;
				fb  = rentry.var_bits;
			end
			STEP_MEAN: begin
				fop = dqc_pkg::OP_ADD;
				fb  = rentry.mean_bits;
			end
			default: begin
				fop = dqc_pkg::OP_CVT;
				fb  = rentry.scale_bits;
			end
		endcase
	end

	dqc_fpu u_fpu (
		.clk   (clk),
		.ctl   (fctl),
		.op    (fop),
		.b_bits(fb),
		.diff  (diff),
		.res   (fres)
	);

	assign result = half_output_q ? to_half(fres) : fres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_channel_q   <= 1'b0;
			channel_count_q <= 9'd1;
			inner_stride_q  <= 25'd1;
			half_output_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dqc_pkg::REG_PER_CHANNEL:   per_channel_q   <= cfg_data[0];
				dqc_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[8:0];
				dqc_pkg::REG_INNER_STRIDE:  inner_stride_q  <= cfg_data;
				dqc_pkg::REG_HALF_OUTPUT:   half_output_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_CVT;
			ip_q        <= 25'd0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_deq) begin
						state_q <= ST_READ;
						if (ip_next >= stride_eff) begin
							ip_q <= 25'd0;
							ch_q <= ch_next[AW-1:0];
						end else begin
							ip_q <= ip_next;
							ch_q <= ch_cur;
						end
					end
				end
				ST_READ: begin
					step_q  <= STEP_CVT;
					state_q <= ST_PRE;
				end
				ST_PRE:  state_q <= ST_NORM;
				ST_NORM: state_q <= ST_RND;
				ST_RND: begin
					if (step_q == STEP_MEAN) begin
						state_q <= ST_OUT;
					end else begin
						step_q  <= step_t'(step_q + 2'd1);
						state_q <= ST_PRE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_deq) begin
			x_q   <= in_data.sample;
			idx_q <= idx;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q.result_bits  <= result;
			out_q.channel_used <= idx_q[7:0];
		end
	end

endmodule
